[src/plgl_pkg.sv]
// Shared types and constants for the piecewise-linear LUT generator.
// No dependencies; imported by every module of the block.
`default_nettype none
package plgl_pkg;

  localparam int MaxPoints  = 16;
  localparam int PtAw       = $clog2(MaxPoints);
  localparam int QuoBits    = 20;
  localparam logic [16:0] OneQ16       = 17'd65536;
  localparam logic [16:0] DefaultSize  = 17'd256;
  localparam logic [16:0] MinSize      = 17'd16;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_ADD     = 2'd1,
    OP_EVAL    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FEW   = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [16:0] m;
    logic [16:0] r;
  } point_t;

  typedef struct packed {
    logic [16:0]        ma;
    logic [16:0]        ra;
    logic [16:0]        dm;
    logic signed [17:0] dr;
  } line_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INS, ST_INS_W, ST_E1, ST_E2, ST_E3, ST_E4, ST_SCAN, ST_ARITH, ST_RES
  } state_e;

  typedef enum logic [2:0] {
    AR_IDLE, AR_MAD, AR_DEN, AR_MUL, AR_PREP, AR_CHK, AR_DIV, AR_FIN
  } ar_state_e;

endpackage
`default_nettype wire

[src/plgl_arith.sv]
// Line evaluation unit: ra + round((tn - ma*den)*dr / (den*dm)), clamped to 0..1.0.
// Bit-serial multiply and restoring divide; depends on plgl_pkg.
`default_nettype none
module plgl_arith import plgl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire line_t       line_i,
  input  wire logic [31:0] tn_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [16:0]      value_o
);

  ar_state_e   state_q, state_d;
  line_t       line_q;
  logic [31:0] tn_q;
  logic [15:0] den_q;
  logic [32:0] mad_q, dd_q;
  logic [33:0] pmag_q;
  logic [16:0] drm_q;
  logic        neg_q, nneg_q;
  logic [50:0] acc_q;
  logic [52:0] num_q;
  logic [33:0] rem_q;
  logic [19:0] numlo_q;
  logic [20:0] q_q;
  logic [4:0]  cnt_q;

  logic [34:0] p, pn;
  logic [17:0] drn;
  logic [52:0] twon, dext;
  logic [35:0] trial;
  logic [21:0] mag;
  logic [22:0] sum;

  always_comb begin
    p     = 35'(tn_q) - 35'(mad_q);
    pn    = -p;
    drn   = -line_q.dr;
    twon  = {1'b0, acc_q, 1'b0};
    dext  = 53'(dd_q);
    trial = {1'b0, rem_q, numlo_q[19]} - {2'b0, dd_q, 1'b0};
    mag   = 22'(q_q) + 22'(nneg_q && (rem_q != '0));
    sum   = 23'(line_q.ra) + (nneg_q ? -23'(mag) : 23'(mag));
    if (sum[22]) begin
      value_o = '0;
    end else if (sum > 23'(OneQ16)) begin
      value_o = OneQ16;
    end else begin
      value_o = sum[16:0];
    end
    done_o  = (state_q == AR_FIN);
    state_d = state_q;
    case (state_q)
      AR_IDLE: if (start_i) state_d = AR_MAD;
      AR_MAD:  state_d = AR_DEN;
      AR_DEN:  state_d = AR_MUL;
      AR_MUL:  if (cnt_q == '0) state_d = AR_PREP;
      AR_PREP: state_d = AR_CHK;
      AR_CHK:  state_d = ({1'b0, num_q} >= {dd_q, 1'b0, 20'b0}) ? AR_FIN : AR_DIV;
      AR_DIV:  if (cnt_q == '0) state_d = AR_FIN;
      AR_FIN:  state_d = AR_IDLE;
      default: state_d = AR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      AR_IDLE: begin
        line_q <= line_i;
        tn_q   <= tn_i;
        den_q  <= den_i;
      end
      AR_MAD: mad_q <= 33'(line_q.ma) * 33'(den_q);
      AR_DEN: begin
        dd_q   <= 33'(den_q) * 33'(line_q.dm);
        pmag_q <= p[34] ? pn[33:0] : p[33:0];
        drm_q  <= line_q.dr[17] ? drn[16:0] : line_q.dr[16:0];
        neg_q  <= p[34] ^ line_q.dr[17];
        acc_q  <= '0;
        cnt_q  <= 5'd16;
      end
      AR_MUL: begin
        acc_q <= {acc_q[49:0], 1'b0} + (drm_q[16] ? 51'(pmag_q) : 51'd0);
        drm_q <= {drm_q[15:0], 1'b0};
        cnt_q <= cnt_q - 5'd1;
      end
      AR_PREP: begin
        if (!neg_q) begin
          num_q  <= twon + dext;
          nneg_q <= 1'b0;
        end else if (twon <= dext) begin
          num_q  <= dext - twon;
          nneg_q <= 1'b0;
        end else begin
          num_q  <= twon - dext;
          nneg_q <= 1'b1;
        end
      end
      AR_CHK: begin
        if ({1'b0, num_q} < {dd_q, 1'b0, 20'b0}) begin
          q_q   <= '0;
          rem_q <= 34'(num_q[52:20]);
        end else begin
          q_q   <= 21'd1 << QuoBits;
          rem_q <= '0;
        end
        numlo_q <= num_q[19:0];
        cnt_q   <= 5'd19;
      end
      AR_DIV: begin
        if (!trial[35]) begin
          rem_q <= trial[33:0];
        end else begin
          rem_q <= {rem_q[32:0], numlo_q[19]};
        end
        q_q     <= {q_q[19:0], ~trial[35]};
        numlo_q <= {numlo_q[18:0], 1'b0};
        cnt_q   <= cnt_q - 5'd1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/piecewise_linear_lut_generation.sv]
// Top level: point memory, insertion sort, bracket search and result register.
// Depends on plgl_pkg and plgl_arith.
// Load: restart never stalls; an add stalls while the insertion sort shifts larger points up.
// Evaluate: errors skip the arithmetic; an interpolation scans for the bracket (up to 15
// point reads), then plgl_arith: 17-step multiply, then 20-step divide unless saturated.
// One transaction in flight; reset empties the point set and sets 256 entries.
`default_nettype none
module piecewise_linear_lut_generation import plgl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [16:0] measured_value_i,
  input  wire logic [16:0] reference_value_i,
  input  wire logic [15:0] entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [16:0]      lut_value_o,
  output logic [1:0]       status_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [0:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  point_t pt_mem [MaxPoints];
  point_t rd_q;

  state_e      state_q, state_d;
  logic [16:0] entries_q;
  logic [4:0]  cnt_q, cnt_d;
  logic [PtAw-1:0] pos_q, pos_d, idx_q, idx_d;
  point_t      new_q, new_d, pa_q, pa_d, pb_q, pb_d;
  logic [31:0] tn_q, tn_d;
  logic [15:0] den_q, den_d;
  logic        le0_q, le0_d;
  logic [16:0] resv_q, resv_d;
  status_e     ress_q, ress_d;
  logic        out_valid_q, out_valid_d;
  logic [16:0] out_val_q, out_val_d;
  status_e     out_st_q, out_st_d;

  logic            we;
  logic [PtAw-1:0] waddr, raddr;
  point_t          wdata;
  logic [16:0]     size;
  logic [32:0]     prod;
  logic            ar_start, ar_done;
  line_t           ar_line;
  logic [16:0]     ar_value;
  logic            out_free;

  assign pready_o    = 1'b1;
  assign prdata_o    = (paddr_i == 1'b0) ? 32'(entries_q) : '0;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign lut_value_o = out_val_q;
  assign status_o    = out_st_q;

  assign size     = (entries_q < MinSize || entries_q > OneQ16) ? DefaultSize : entries_q;
  assign prod     = 33'(rd_q.m) * 33'(den_q);
  assign out_free = !out_valid_q || !out_stall_i;

  plgl_arith u_arith (
    .clk_i,
    .rst_ni,
    .start_i (ar_start),
    .line_i  (ar_line),
    .tn_i    (tn_q),
    .den_i   (den_q),
    .done_o  (ar_done),
    .value_o (ar_value)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    new_d    = new_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    tn_d     = tn_q;
    den_d    = den_q;
    le0_d    = le0_q;
    resv_d   = resv_q;
    ress_d   = ress_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = new_q;
    raddr    = '0;
    ar_start = 1'b0;
    ar_line  = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          new_d = '{m: measured_value_i, r: reference_value_i};
          case (opcode_e'(opcode_i))
            OP_RESTART: begin
              we    = 1'b1;
              wdata = '{m: measured_value_i, r: reference_value_i};
              cnt_d = 5'd1;
            end
            OP_ADD: begin
              wdata = '{m: measured_value_i, r: reference_value_i};
              if (cnt_q == 5'd0) begin
                we    = 1'b1;
                cnt_d = 5'd1;
              end else if (cnt_q < 5'(MaxPoints)) begin
                pos_d   = cnt_q[PtAw-1:0];
                raddr   = cnt_q[PtAw-1:0] - PtAw'(1);
                state_d = ST_INS;
              end
            end
            OP_EVAL: begin
              tn_d  = {entry_index_i, 16'b0};
              den_d = 16'(size - 17'd1);
              if (cnt_q < 5'd3) begin
                resv_d  = '0;
                ress_d  = STAT_FEW;
                state_d = ST_RES;
              end else if (17'(entry_index_i) >= size) begin
                resv_d  = '0;
                ress_d  = STAT_RANGE;
                state_d = ST_RES;
              end else begin
                state_d = ST_E1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INS: begin
        we    = 1'b1;
        waddr = pos_q;
        if (rd_q.m > new_q.m) begin
          wdata = rd_q;
          pos_d = pos_q - PtAw'(1);
          if (pos_q == PtAw'(1)) begin
            state_d = ST_INS_W;
          end else begin
            raddr = pos_q - PtAw'(2);
          end
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = ST_IDLE;
        end
      end
      ST_INS_W: begin
        we      = 1'b1;
        cnt_d   = cnt_q + 5'd1;
        state_d = ST_IDLE;
      end
      ST_E1: begin
        pa_d    = rd_q;
        le0_d   = (33'(tn_q) <= prod);
        raddr   = PtAw'(1);
        state_d = ST_E2;
      end
      ST_E2: begin
        if (le0_q) begin
          if (rd_q.m > pa_q.m) begin
            ar_start = 1'b1;
            ar_line  = '{ma: '0, ra: '0, dm: rd_q.m, dr: {1'b0, rd_q.r}};
            state_d  = ST_ARITH;
          end else begin
            resv_d  = '0;
            ress_d  = STAT_OK;
            state_d = ST_RES;
          end
        end else begin
          raddr   = cnt_q[PtAw-1:0] - PtAw'(1);
          state_d = ST_E3;
        end
      end
      ST_E3: begin
        if (33'(tn_q) >= prod) begin
          pb_d    = rd_q;
          raddr   = cnt_q[PtAw-1:0] - PtAw'(2);
          state_d = ST_E4;
        end else begin
          raddr   = PtAw'(1);
          idx_d   = PtAw'(1);
          state_d = ST_SCAN;
        end
      end
      ST_E4: begin
        if (pb_q.m > rd_q.m) begin
          ar_start = 1'b1;
          ar_line  = '{ma: pb_q.m, ra: pb_q.r, dm: pb_q.m - rd_q.m,
                       dr: {1'b0, pb_q.r} - {1'b0, rd_q.r}};
          state_d  = ST_ARITH;
        end else begin
          resv_d  = OneQ16;
          ress_d  = STAT_OK;
          state_d = ST_RES;
        end
      end
      ST_SCAN: begin
        if (prod >= 33'(tn_q)) begin
          ar_start = 1'b1;
          ar_line  = '{ma: pa_q.m, ra: pa_q.r, dm: rd_q.m - pa_q.m,
                       dr: {1'b0, rd_q.r} - {1'b0, pa_q.r}};
          state_d  = ST_ARITH;
        end else begin
          pa_d  = rd_q;
          idx_d = idx_q + PtAw'(1);
          raddr = idx_q + PtAw'(1);
        end
      end
      ST_ARITH: begin
        if (ar_done) begin
          resv_d  = ar_value;
          ress_d  = STAT_OK;
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = resv_q;
          out_st_d    = ress_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      pt_mem[waddr] <= wdata;
    end
    rd_q <= pt_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      entries_q   <= DefaultSize;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (psel_i && penable_i && pwrite_i && paddr_i == 1'b0) begin
        entries_q <= pwdata_i[16:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    idx_q     <= idx_d;
    new_q     <= new_d;
    pa_q      <= pa_d;
    pb_q      <= pb_d;
    tn_q      <= tn_d;
    den_q     <= den_d;
    le0_q     <= le0_d;
    resv_q    <= resv_d;
    ress_q    <= ress_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

endmodule
`default_nettype wire

[src/plgl_checker.sv]
// Port-level checks for the LUT generator, bound to the top level.
// Depends on plgl_pkg.
`default_nettype none
module plgl_checker import plgl_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [16:0] lut_value_o,
  input wire logic [1:0]  status_o,
  input wire logic        pready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lut_value_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FEW || status_o == STAT_RANGE) |-> lut_value_o == '0)
    else $error("error status with nonzero value");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lut_value_o <= OneQ16 && status_o <= STAT_RANGE)
    else $error("result out of range");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("config port not ready");

endmodule

bind piecewise_linear_lut_generation plgl_checker u_plgl_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_stall_i,
  .lut_value_o,
  .status_o,
  .pready_o
);
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for piecewise_linear_lut_generation: loads point sets,
// evaluates LUT entries under random valid/stall gaps, checks against a local model.
// Depends on plgl_pkg and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none
module tb import plgl_pkg::*;;

  class lut_scoreboard;
    logic [16:0] pt_m[MaxPoints];
    logic [16:0] pt_r[MaxPoints];
    int unsigned n_pts;
    logic [16:0] size_reg;
    logic [16:0] exp_value[$];
    status_e     exp_status[$];
    int          n_errors;

    function new();
      n_pts = 0;
      size_reg = DefaultSize;
      n_errors = 0;
    endfunction

    function longint div_round(longint n, longint d);
      longint nn;
      longint dd;
      longint q;
      nn = 2 * n + d;
      dd = 2 * d;
      q = nn / dd;
      if (nn < 0 && q * dd != nn) q--;
      return q;
    endfunction

    function longint line_val(int a, int b, longint k, longint den);
      longint ma;
      longint ra;
      longint dm;
      longint dr;
      ma = pt_m[a];
      ra = pt_r[a];
      dm = longint'(pt_m[b]) - ma;
      dr = longint'(pt_r[b]) - ra;
      if (dm < 0) begin
        dm = -dm;
        dr = -dr;
      end
      return ra + div_round((k * 65536 - ma * den) * dr, den * dm);
    endfunction

    function void add_point(logic [16:0] m, logic [16:0] r);
      int p;
      if (n_pts >= MaxPoints) return;
      p = n_pts;
      while (p > 0 && pt_m[p-1] > m) begin
        pt_m[p] = pt_m[p-1];
        pt_r[p] = pt_r[p-1];
        p--;
      end
      pt_m[p] = m;
      pt_r[p] = r;
      n_pts++;
    endfunction

    function logic [16:0] interp(longint k, longint den);
      longint tn;
      longint v;
      int i;
      int n;
      n = n_pts;
      tn = k * 65536;
      if (tn <= longint'(pt_m[0]) * den) begin
        if (pt_m[1] > pt_m[0]) v = div_round(tn * pt_r[1], den * pt_m[1]);
        else v = 0;
      end else if (tn >= longint'(pt_m[n-1]) * den) begin
        if (pt_m[n-1] > pt_m[n-2]) v = line_val(n - 1, n - 2, k, den);
        else v = 65536;
      end else begin
        i = 0;
        while (i < n - 1 && longint'(pt_m[i+1]) * den < tn) i++;
        if (i >= n - 1) i = n - 2;
        v = line_val(i, i + 1, k, den);
      end
      if (v < 0) v = 0;
      if (v > 65536) v = 65536;
      return v[16:0];
    endfunction

    function void note_input(opcode_e op, logic [16:0] m, logic [16:0] r,
                             logic [15:0] k);
      int unsigned sz;
      if (op == OP_RESTART) begin
        n_pts = 0;
        add_point(m, r);
      end else if (op == OP_ADD) begin
        add_point(m, r);
      end else if (op == OP_EVAL) begin
        sz = size_reg;
        if (sz < 16 || sz > 65536) sz = 256;
        if (n_pts < 3) begin
          exp_value.push_back(17'd0);
          exp_status.push_back(STAT_FEW);
        end else if (k >= sz) begin
          exp_value.push_back(17'd0);
          exp_status.push_back(STAT_RANGE);
        end else begin
          exp_value.push_back(interp(k, sz - 1));
          exp_status.push_back(STAT_OK);
        end
      end
    endfunction

    function void check_result(logic [16:0] v, logic [1:0] s);
      logic [16:0] ev;
      status_e es;
      if (exp_value.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected transaction: value %0d status %0d", v, s);
        return;
      end
      ev = exp_value.pop_front();
      es = exp_status.pop_front();
      if (v !== ev || s !== es) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                   ev, es, v, s);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [1:0]  opcode;
  logic [16:0] meas, refv;
  logic [15:0] index;
  logic        out_valid, out_stall;
  logic [16:0] lut_value;
  logic [1:0]  status;
  logic        psel, penable, pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  lut_scoreboard sb;
  int          idle_cycles;

  piecewise_linear_lut_generation u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .measured_value_i(meas), .reference_value_i(refv),
    .entry_index_i(index),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .lut_value_o(lut_value), .status_o(status),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(opcode_e op, logic [16:0] m, logic [16:0] r, logic [15:0] k);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    meas <= m;
    refv <= r;
    index <= k;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, m, r, k);
    idle_cycles = 0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.exp_value.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_size(logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= val;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    sb.size_reg = val[16:0];
  endtask

  task automatic rand_set(int n, bit wide);
    for (int i = 0; i < n; i++) begin
      send(i == 0 ? OP_RESTART : OP_ADD,
           wide ? 17'($urandom) : 17'($urandom_range(0, 65536)),
           wide ? 17'($urandom) : 17'($urandom_range(0, 65536)), 16'($urandom));
    end
  endtask

  // output side: random stalls, compare on each accepted transaction
  initial begin
    int g;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      g = gap_len();
      if (g != 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      if (out_valid) begin
        sb.check_result(lut_value, status);
        idle_cycles = 0;
      end
    end
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int sizes[6];
    int items;
    int sz;
    int r;
    int n;
    sb = new();
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    opcode = OP_NONE;
    meas = '0;
    refv = '0;
    index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send(OP_EVAL, 0, 0, 0);
    send(OP_RESTART, 17'd0, 17'd0, 0);
    send(OP_ADD, 17'd65536, 17'd65536, 0);
    send(OP_EVAL, 0, 0, 5);
    send(OP_ADD, 17'd32768, 17'd40000, 0);
    send(OP_EVAL, 0, 0, 0);
    send(OP_EVAL, 0, 0, 128);
    send(OP_EVAL, 0, 0, 255);
    send(OP_EVAL, 0, 0, 256);
    send(OP_EVAL, 0, 0, 16'hFFFF);
    send(OP_NONE, 17'h1FFFF, 17'h1FFFF, 16'hFFFF);
    send(OP_RESTART, 17'd20000, 17'd10000, 0);
    send(OP_ADD, 17'd20000, 17'd30000, 0);
    send(OP_ADD, 17'd40000, 17'd50000, 0);
    send(OP_ADD, 17'd40000, 17'd50000, 0);
    send(OP_EVAL, 0, 0, 10);
    send(OP_EVAL, 0, 0, 250);
    send(OP_RESTART, 17'h1FFFF, 17'h1FFFF, 0);
    send(OP_ADD, 17'd1000, 17'd0, 0);
    send(OP_ADD, 17'd5000, 17'h1FFFF, 0);
    send(OP_EVAL, 0, 0, 1);
    send(OP_EVAL, 0, 0, 200);
    drain();

    // set full, extra adds ignored
    rand_set(18, 0);
    send(OP_EVAL, 0, 0, 100);

    sizes = '{16, 15, 65536, 17'h1FFFF, 1000, 256};
    items = 0;
    foreach (sizes[j]) begin
      drain();
      write_size(sizes[j]);
      sz = (sizes[j] < 16 || sizes[j] > 65536) ? 256 : sizes[j];
      while (items < (j + 1) * 260) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          n = $urandom_range(1, 17);
          rand_set(n, $urandom_range(0, 9) == 0);
          items += n - 1;
        end else if (r < 85) begin
          send(OP_EVAL, 0, 0, 16'($urandom_range(0, sz - 1)));
        end else if (r < 93) begin
          send(OP_EVAL, 0, 0, 16'($urandom));
        end else if (r < 97) begin
          send(OP_ADD, 17'($urandom), 17'($urandom), 16'($urandom));
        end else begin
          send(OP_NONE, 17'($urandom), 17'($urandom), 16'($urandom));
        end
        items++;
      end
    end

    drain();
    if (sb.n_errors == 0 && sb.exp_value.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
